/* design/gcd_rmrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_rmrc_pkg
// Shared types for the gcd / reduced-step / range-count core: sequencer
// states and the status bundle of the shared shift-subtract divider.
// ----------------------------------------------------------------------------
package gcd_rmrc_pkg;

  // Sequencer states of the core
  typedef enum logic [3:0] {
    ST_IDLE,       // waiting for a request beat
    ST_GCD,        // Euclid step: test y, issue x % y
    ST_GCD_WAIT,   // waiting on x % y
    ST_STEP,       // issue modulus / gcd
    ST_STEP_WAIT,  // waiting on modulus / gcd
    ST_HI,         // empty-range check, issue high / step
    ST_HI_WAIT,    // waiting on high / step
    ST_LO_WAIT,    // waiting on (low - 1) / step
    ST_DONE        // result ready for the output register
  } seq_state_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;  // division in progress
    logic done;  // one-cycle pulse, quotient and remainder valid
  } div_stat_t;

endpackage
`default_nettype wire

/* design/gcd_reduced_multiple_range_count_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_reduced_multiple_range_count_core
// g = gcd(multiplier, modulus) by Euclid, step = modulus / g, and the count
// of multiples of step in [low, high] as high/step - (low-1)/step.
//
//   channel | dir | beat contents (low bits first)
//   --------+-----+-----------------------------------------------------
//   in_*    | in  | range_low, range_high, multiplier, modulus
//   out_*   | out | match_count, common_divisor, reduced_step
//
// One request at a time. Every quotient and remainder comes from one
// shared shift-subtract divider at one bit per cycle. A request runs one
// division per Euclid remainder step, then at most the step division and
// the two count divisions (at most ~90 Euclid remainder steps for 63 bits).
// Reset (rst_n low, synchronous) empties the sequencer and output register.
// A stalled result waits in the output register; the next request is taken
// meanwhile and holds in ST_DONE only if the register is still full.
// ----------------------------------------------------------------------------
module gcd_reduced_multiple_range_count_core #(
  parameter int VALUE_BITS = 63
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // range_low, range_high, multiplier, modulus, zero pad
  input  logic [((4*VALUE_BITS+7)/8)*8-1:0]         in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // match_count, common_divisor, reduced_step, zero pad
  output logic [((3*VALUE_BITS+7)/8)*8-1:0]         out_tdata
);
  import gcd_rmrc_pkg::*;

  localparam int W           = VALUE_BITS;
  localparam int OUT_TDATA_W = ((3*VALUE_BITS+7)/8)*8;

  seq_state_t state_r, state_nxt;
  logic [W-1:0] lo_r, lo_nxt;
  logic [W-1:0] hi_r, hi_nxt;
  logic [W-1:0] mod_r, mod_nxt;
  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] y_r, y_nxt;
  logic [W-1:0] g_r, g_nxt;
  logic [W-1:0] step_r, step_nxt;
  logic [W-1:0] qhi_r, qhi_nxt;
  logic [W-1:0] cnt_r, cnt_nxt;

  logic         out_tvalid_r, out_tvalid_nxt;
  logic [W-1:0] o_cnt_r, o_cnt_nxt;
  logic [W-1:0] o_g_r, o_g_nxt;
  logic [W-1:0] o_step_r, o_step_nxt;

  logic         div_start;
  logic [W-1:0] div_a, div_b;
  div_stat_t    div_stat;
  logic [W-1:0] div_q, div_r;
  logic         load_out;
  logic [W-1:0] in_lo;

  assign in_tready = (state_r == ST_IDLE);
  assign in_lo     = in_tdata[W-1:0];
  assign load_out  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Shared divider
  gcd_rmrc_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Sequencer: next state, divider operands, working registers
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mod_nxt   = mod_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    g_nxt     = g_r;
    step_nxt  = step_r;
    qhi_nxt   = qhi_r;
    cnt_nxt   = cnt_r;
    div_start = 1'b0;
    div_a     = x_r;
    div_b     = y_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // low bound 0 counts as 1
          lo_nxt    = (in_lo == '0) ? W'(1) : in_lo;
          hi_nxt    = in_tdata[2*W-1:W];
          x_nxt     = in_tdata[3*W-1:2*W];
          y_nxt     = in_tdata[4*W-1:3*W];
          mod_nxt   = in_tdata[4*W-1:3*W];
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (y_r == '0) begin
          g_nxt     = x_r;
          state_nxt = ST_STEP;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_stat.done) begin
          x_nxt     = y_r;
          y_nxt     = div_r;
          state_nxt = ST_GCD;
        end
      end
      ST_STEP: begin
        if (g_r == '0) begin
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          div_a     = mod_r;
          div_b     = g_r;
          div_start = 1'b1;
          state_nxt = ST_STEP_WAIT;
        end
      end
      ST_STEP_WAIT: begin
        if (div_stat.done) begin
          step_nxt  = div_q;
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        // zero step or empty range counts nothing
        if (step_r == '0 || lo_r > hi_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          div_a     = hi_r;
          div_b     = step_r;
          div_start = 1'b1;
          state_nxt = ST_HI_WAIT;
        end
      end
      ST_HI_WAIT: begin
        if (div_stat.done) begin
          qhi_nxt   = div_q;
          div_a     = lo_r - W'(1);
          div_b     = step_r;
          div_start = 1'b1;
          state_nxt = ST_LO_WAIT;
        end
      end
      ST_LO_WAIT: begin
        if (div_stat.done) begin
          cnt_nxt   = qhi_r - div_q;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    o_cnt_nxt      = o_cnt_r;
    o_g_nxt        = o_g_r;
    o_step_nxt     = o_step_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      o_cnt_nxt      = cnt_r;
      o_g_nxt        = g_r;
      o_step_nxt     = step_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mod_r    <= mod_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    g_r      <= g_nxt;
    step_r   <= step_nxt;
    qhi_r    <= qhi_nxt;
    cnt_r    <= cnt_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_g_r    <= o_g_nxt;
    o_step_r <= o_step_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({o_step_r, o_g_r, o_cnt_r});

  // Checks
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_tvalid_r && state_r == ST_IDLE))
    else $error("finished result not registered");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_GCD_WAIT || state_r == ST_STEP_WAIT ||
                       state_r == ST_HI_WAIT || state_r == ST_LO_WAIT))
    else $error("divider result arrived outside a wait state");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HI_WAIT || state_r == ST_LO_WAIT) |-> step_r != '0)
    else $error("count division by a zero step");
  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD || state_r == ST_STEP || state_r == ST_HI) |-> !div_stat.busy)
    else $error("divider busy when a division is issued");

endmodule
`default_nettype wire

/* design/gcd_rmrc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_rmrc_div
// Restoring shift-subtract divider, one quotient bit per cycle. Shared by
// the Euclid loop, the step division and both count divisions.
// ----------------------------------------------------------------------------
module gcd_rmrc_div #(
  parameter int W = 63
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [W-1:0]             dividend,
  input  logic [W-1:0]             divisor,
  output gcd_rmrc_pkg::div_stat_t  stat,
  output logic [W-1:0]             quotient,
  output logic [W-1:0]             remainder
);
  import gcd_rmrc_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // One restoring step: shift in next dividend bit, try subtract
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with spent bit count");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dvs_r != '0) |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
